// ===== src/mic_gain_saturate_ring_writer_assert.svh =====
// Assertion macros for the microphone gain and ring writer block.
`ifndef MIC_GAIN_SATURATE_RING_WRITER_ASSERT_SVH
`define MIC_GAIN_SATURATE_RING_WRITER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MGSRW_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define MGSRW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MGSRW_ASSERT_NOW(label, clk, rstn, ante, cons)
`define MGSRW_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== src/mgsrw_pkg.sv =====
package mgsrw_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned PROD_W   = SAMPLE_W + GAIN_W + 1;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(8);
    localparam logic [ADDR_W-1:0] ADDR_STEP  = ADDR_W'(2);

    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(32768);

    typedef enum logic {
        REG_GAIN       = 1'b0,
        REG_RING_BYTES = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [ADDR_W-1:0]          byte_address;
        logic signed [SAMPLE_W-1:0] sample;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== src/mic_gain_saturate_ring_writer.sv =====
// Channel   Dir  Ports            Payload
// input     in   s_axis_t*        tdata: sample_word; tuser: channel_right, recenter
// result    out  m_axis_t*        tdata: byte_address, sample
// config    in   cfg_*            index 0 gain, index 1 ring_bytes
//
// One word per cycle while the queue is not full; a left word passes through the queue slot,
// the product register and the saturate register before it leaves.
// Right words leave no result and do not step the write position; recenter and wrap still apply.
// Reset is synchronous; gain returns to 8, ring size and position to 0.
// A stalled output holds the back pipeline; the four-entry queue keeps input open until it is full.
`include "mic_gain_saturate_ring_writer_assert.svh"

module mic_gain_saturate_ring_writer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // [31:0] sample_word
    input  logic [1:0]                       s_axis_tuser,  // [0] channel_right, [1] recenter
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // [15:0] byte_address, [31:16] sample
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [15:0]                      cfg_wdata
);

    logic [mgsrw_pkg::GAIN_W-1:0] gain_reg;
    logic [mgsrw_pkg::ADDR_W-1:0] ring_bytes_reg;
    mgsrw_pkg::q_stat_t           q_stat;
    mgsrw_pkg::entry_t            push_entry;
    mgsrw_pkg::entry_t            pop_entry;
    mgsrw_pkg::entry_t            out_entry;
    logic                         push;
    logic                         pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg       <= mgsrw_pkg::GAIN_RESET;
            ring_bytes_reg <= '0;
        end else if (cfg_we) begin
            case (mgsrw_pkg::reg_index_t'(cfg_index))
                mgsrw_pkg::REG_GAIN:       gain_reg       <= cfg_wdata;
                mgsrw_pkg::REG_RING_BYTES: ring_bytes_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mgsrw_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_word     (s_axis_tdata),
        .in_right    (s_axis_tuser[0]),
        .in_recenter (s_axis_tuser[1]),
        .ring_bytes  (ring_bytes_reg),
        .q_stat      (q_stat),
        .in_ready    (s_axis_tready),
        .push        (push),
        .push_entry  (push_entry)
    );

    mgsrw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    mgsrw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain      (gain_reg),
        .q_stat    (q_stat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_entry (out_entry)
    );

    assign m_axis_tdata = {out_entry.sample, out_entry.byte_address};

    `MGSRW_ASSERT_NOW(a_queue_state, aclk, aresetn, 1'b1, !(q_stat.full && q_stat.empty))
    `MGSRW_ASSERT_NOW(a_addr_in_ring, aclk, aresetn, push,
        (push_entry.byte_address < ring_bytes_reg) || (push_entry.byte_address == '0))
    `MGSRW_ASSERT_NEXT(a_push_lands, aclk, aresetn, push, !q_stat.empty)

endmodule

// ===== src/mgsrw_front.sv =====
module mgsrw_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [mgsrw_pkg::WORD_W-1:0]  in_word,
    input  logic                          in_right,
    input  logic                          in_recenter,
    input  logic [mgsrw_pkg::ADDR_W-1:0]  ring_bytes,
    input  mgsrw_pkg::q_stat_t            q_stat,
    output logic                          in_ready,
    output logic                          push,
    output mgsrw_pkg::entry_t             push_entry
);

    logic [mgsrw_pkg::ADDR_W-1:0] position_reg;
    logic [mgsrw_pkg::ADDR_W-1:0] position_next;
    logic [mgsrw_pkg::ADDR_W-1:0] base;
    logic [mgsrw_pkg::ADDR_W-1:0] wrapped;
    logic                         accept;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && !in_right;

    always_comb begin
        base    = in_recenter ? (ring_bytes >> 1) : position_reg;
        wrapped = (base >= ring_bytes) ? '0 : base;
        position_next = position_reg;
        if (accept) begin
            position_next = in_right ? wrapped : wrapped + mgsrw_pkg::ADDR_STEP;
        end
        push_entry.byte_address = wrapped;
        push_entry.sample       = $signed(in_word[mgsrw_pkg::WORD_W-1 -: mgsrw_pkg::SAMPLE_W]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
        end else begin
            position_reg <= position_next;
        end
    end

endmodule

// ===== src/mgsrw_queue.sv =====
module mgsrw_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mgsrw_pkg::entry_t  push_entry,
    input  logic               pop,
    output mgsrw_pkg::entry_t  pop_entry,
    output mgsrw_pkg::q_stat_t q_stat
);

    mgsrw_pkg::entry_t             slots_reg [mgsrw_pkg::QDEPTH];
    logic [mgsrw_pkg::QAW-1:0]     wr_ptr_reg;
    logic [mgsrw_pkg::QAW-1:0]     wr_ptr_next;
    logic [mgsrw_pkg::QAW-1:0]     rd_ptr_reg;
    logic [mgsrw_pkg::QAW-1:0]     rd_ptr_next;
    logic [mgsrw_pkg::QCW-1:0]     count_reg;
    logic [mgsrw_pkg::QCW-1:0]     count_next;
    logic                          do_push;
    logic                          do_pop;

    assign q_stat.full  = (count_reg == mgsrw_pkg::QCW'(mgsrw_pkg::QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_entry    = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/mgsrw_back.sv =====
module mgsrw_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mgsrw_pkg::GAIN_W-1:0]  gain,
    input  mgsrw_pkg::q_stat_t            q_stat,
    input  mgsrw_pkg::entry_t             pop_entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mgsrw_pkg::entry_t             out_entry
);

    logic                                 advance;
    logic                                 prod_valid_reg;
    logic signed [mgsrw_pkg::PROD_W-1:0]  prod_reg;
    logic [mgsrw_pkg::ADDR_W-1:0]         prod_addr_reg;
    logic                                 out_valid_reg;
    mgsrw_pkg::entry_t                    out_entry_reg;
    logic signed [mgsrw_pkg::PROD_W-1:0]  product;
    logic signed [mgsrw_pkg::SAMPLE_W-1:0] saturated;

    assign advance   = !out_valid_reg || out_ready;
    assign pop       = advance && !q_stat.empty;
    assign out_valid = out_valid_reg;
    assign out_entry = out_entry_reg;

    always_comb begin
        product = pop_entry.sample * $signed({1'b0, gain});
        if (prod_reg > mgsrw_pkg::SAT_MAX) begin
            saturated = mgsrw_pkg::SAT_MAX[mgsrw_pkg::SAMPLE_W-1:0];
        end else if (prod_reg < mgsrw_pkg::SAT_MIN) begin
            saturated = mgsrw_pkg::SAT_MIN[mgsrw_pkg::SAMPLE_W-1:0];
        end else begin
            saturated = prod_reg[mgsrw_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (advance) begin
            prod_valid_reg <= pop;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg                   <= product;
            prod_addr_reg              <= pop_entry.byte_address;
            out_entry_reg.byte_address <= prod_addr_reg;
            out_entry_reg.sample       <= saturated;
        end
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mgsrw_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_DIR       = 27;
    localparam int N_RANDOM    = 1600;
    localparam int DRAIN_WAIT  = 8;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        reg_index_t         idx;
        logic [15:0]        value;
        logic [31:0]        word;
        bit                 right;
        bit                 recenter;
        bit                 typed;
        logic [15:0]        addr;
        logic signed [15:0] smp;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] sample_word
    logic [1:0]  s_axis_tuser = '0;   // [0] channel_right, [1] recenter
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [15:0] byte_address, [31:16] sample
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = '0;

    logic [15:0] gain_r = 16'd8;
    logic [15:0] ring_r = 16'd0;
    logic [15:0] wr_pos = 16'd0;
    entry_t      pending_samples[$];
    int          errors = 0;
    int          cycles = 0;
    bit          src_burst = 1'b0;

    row_t dir_rows [N_DIR] = '{
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h0001_0000, 1'b0, 1'b0, 1'b1, 16'd0, 16'sd8},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 16'd0, -16'sd8},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h7FFF_0000, 1'b0, 1'b0, 1'b1, 16'd0, 16'sh7FFF},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h8000_FFFF, 1'b0, 1'b0, 1'b1, 16'd0, 16'sh8000},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h1234_5678, 1'b1, 1'b1, 1'b0, 16'd0, 16'sd0},
        '{ROW_CFG, REG_GAIN, 16'd0, 32'h0, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 16'd0, 16'sd0},
        '{ROW_CFG, REG_GAIN, 16'hFFFF, 32'h0, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_CFG, REG_RING_BYTES, 16'd10, 32'h0, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h0001_0000, 1'b0, 1'b1, 1'b1, 16'd5, 16'sh7FFF},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'hAAAA_5555, 1'b1, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h5555_AAAA, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_CFG, REG_RING_BYTES, 16'd7, 32'h0, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h0002_0000, 1'b0, 1'b1, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'hFFFE_8000, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h4000_7FFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_CFG, REG_RING_BYTES, 16'd65534, 32'h0, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_CFG, REG_GAIN, 16'd1, 32'h0, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'hC000_0000, 1'b0, 1'b1, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h3FFF_0000, 1'b1, 1'b1, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h0100_0000, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_CFG, REG_RING_BYTES, 16'd0, 32'h0, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0},
        '{ROW_WORD, REG_GAIN, 16'd0, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 16'd0, 16'sh8000},
        '{ROW_CFG, REG_GAIN, 16'd8, 32'h0, 1'b0, 1'b0, 1'b0, 16'd0, 16'sd0}
    };

    mic_gain_saturate_ring_writer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // advance the write position for one word; returns 1 when a sample is placed
    function automatic bit place_sample(input logic [31:0] word, input bit right,
                                        input bit recenter, output entry_t e);
        longint prod;
        if (recenter)
            wr_pos = ring_r >> 1;
        if (wr_pos >= ring_r)
            wr_pos = 16'd0;
        if (right)
            return 1'b0;
        prod = longint'($signed(word[31:16])) * longint'(gain_r);
        if (prod > 32767)
            prod = 32767;
        if (prod < -32768)
            prod = -32768;
        e.byte_address = wr_pos;
        e.sample       = prod[15:0];
        wr_pos         = wr_pos + 16'd2;
        return 1'b1;
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 19))
            0: w[31:16] = 16'h7FFF;
            1: w[31:16] = 16'h8000;
            2: w[31:16] = 16'hFFFF;
            3: w[31:16] = 16'h0000;
            4: w[31:16] = 16'h0001;
            5: w[31:16] = 16'($urandom_range(0, 255) - 128);
            default: ;
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (errors < 200)
            $display("mismatch %s at cycle %0d: got %0d expected %0d",
                     what, cycles, got, exp_val);
        errors++;
    endtask

    task automatic send_word(input logic [31:0] word, input bit right, input bit recenter,
                             input bit typed, input logic [15:0] taddr,
                             input logic signed [15:0] tsmp);
        int     gap;
        entry_t e;
        gap = src_burst ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= {recenter, right};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (place_sample(word, right, recenter, e)) begin
            if (typed) begin
                e.byte_address = taddr;
                e.sample       = tsmp;
            end
            pending_samples.push_back(e);
        end
    endtask

    // hold input idle until every pending word is out and the pipeline is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == REG_GAIN)
            gain_r = value;
        else
            ring_r = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int          sink_left;
        entry_t      e;
        logic [15:0] got_addr;
        logic [15:0] got_smp;
        sink_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                got_addr = m_axis_tdata[15:0];
                got_smp  = m_axis_tdata[31:16];
                if (pending_samples.size() == 0) begin
                    report_mismatch("unexpected word, byte_address", got_addr, -1);
                end else begin
                    e = pending_samples.pop_front();
                    if (got_addr !== e.byte_address)
                        report_mismatch("byte_address", got_addr, e.byte_address);
                    if (got_smp !== e.sample)
                        report_mismatch("sample", $signed(got_smp), e.sample);
                end
            end
            if (sink_left != 0) begin
                sink_left--;
            end else if (m_axis_tready) begin
                sink_left = pick_gap();
                if (sink_left != 0)
                    m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                sink_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 20);
            end
        end
    end

    initial begin
        int          sent;
        int          n;
        bit          ch;
        bit          rc;
        logic [15:0] g;
        logic [15:0] rb;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].value);
            end else begin
                send_word(dir_rows[i].word, dir_rows[i].right, dir_rows[i].recenter,
                          dir_rows[i].typed, dir_rows[i].addr, dir_rows[i].smp);
            end
        end

        sent = 0;
        ch   = 1'b1;
        while (sent < N_RANDOM) begin
            settle();
            case ($urandom_range(0, 6))
                0: g = 16'd0;
                1: g = 16'd1;
                2: g = 16'hFFFF;
                3: g = 16'd8;
                4: g = 16'($urandom_range(0, 65535));
                default: g = 16'($urandom_range(0, 64));
            endcase
            case ($urandom_range(0, 6))
                0: rb = 16'd0;
                1: rb = 16'd2;
                2: rb = 16'd65534;
                3: rb = 16'($urandom_range(1, 65534));
                default: rb = 16'($urandom_range(0, 80));
            endcase
            write_reg(REG_GAIN, g);
            write_reg(REG_RING_BYTES, rb);
            src_burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(40, 200);
            repeat (n) begin
                // mostly alternate slots as an I2S frame does
                if ($urandom_range(0, 9) == 0)
                    ch = 1'($urandom_range(0, 1));
                else
                    ch = ~ch;
                rc = ($urandom_range(0, 19) == 0);
                send_word(random_word(), ch, rc, 1'b0, 16'd0, 16'sd0);
                sent++;
            end
        end
        src_burst = 1'b0;
        settle();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== mic_gain_saturate_ring_writer.f =====
+incdir+src
src/mgsrw_pkg.sv
src/mgsrw_front.sv
src/mgsrw_queue.sv
src/mgsrw_back.sv
src/mic_gain_saturate_ring_writer.sv
tb/tb.sv
